[design/arc_pkg.sv]
// Package with shared constants and types of the ARP resolution cache.
package arc_pkg;
	localparam int CacheEntriesDef = 16;
	localparam int QueueEntriesDef = 16;

	localparam logic [1:0] CMD_SEND   = 2'd0;
	localparam logic [1:0] CMD_FRAME  = 2'd1;
	localparam logic [1:0] CMD_TICK   = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [1:0] KIND_OTHER = 2'd0;
	localparam logic [1:0] KIND_IPV4  = 2'd1;
	localparam logic [1:0] KIND_ARP   = 2'd2;

	localparam logic [2:0] ACT_IPV4    = 3'd0;
	localparam logic [2:0] ACT_ARP_REQ = 3'd1;
	localparam logic [2:0] ACT_ARP_REP = 3'd2;
	localparam logic [2:0] ACT_DELIVER = 3'd3;
	localparam logic [2:0] ACT_DROP    = 3'd4;

	localparam logic [1:0] REG_OWN_MAC  = 2'd0;
	localparam logic [1:0] REG_OWN_IP   = 2'd1;
	localparam logic [1:0] REG_PEND_TO  = 2'd2;
	localparam logic [1:0] REG_LIFETIME = 2'd3;

	localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;
	localparam logic [15:0] PEND_TO_RST  = 16'd5000;
	localparam logic [15:0] LIFETIME_RST = 16'd30000;

	typedef struct packed {
		logic [2:0]  action;
		logic [47:0] dest_mac;
		logic [31:0] arp_target;
		logic [15:0] out_handle;
	} result_t;
endpackage

[design/arp_resolution_cache_top.sv]
// Top level of the ARP resolution cache: sequencer over cache and queue tables.
//
//  channel | signals                                     | handshake
//  input   | in_valid, in_stall, cmd .. elapsed_ms       | valid && !stall
//  output  | out_valid, out_stall, action .. out_handle  | valid && !stall
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data   | valid && ready
//
// A send or an ARP frame walks the cache one entry a cycle through a single compare unit,
// then the queue. A tick walks the cache once. Other frames skip both walks.
// Reset clears all valid bits at once; no clearing pass is needed.
// The next item is accepted while a result still waits in the output register,
// but a new result is held back until the previous one is transferred.
module arp_resolution_cache_top
	import arc_pkg::*;
#(
	parameter int CACHE_ENTRIES = CacheEntriesDef,
	parameter int QUEUE_ENTRIES = QueueEntriesDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [31:0] hop_ip,
	input  logic [15:0] datagram_handle,
	input  logic [47:0] frame_dst_mac,
	input  logic [1:0]  frame_kind,
	input  logic        payload_ok,
	input  logic        arp_is_reply,
	input  logic [31:0] arp_sender_ip,
	input  logic [47:0] arp_sender_mac,
	input  logic [31:0] arp_target_ip,
	input  logic [15:0] elapsed_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  action,
	output logic [47:0] dest_mac,
	output logic [31:0] arp_target,
	output logic [15:0] out_handle,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	localparam int CW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int QW = (QUEUE_ENTRIES > 1) ? $clog2(QUEUE_ENTRIES) : 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CSCAN = 3'd1; // walk cache: find, free slot, oldest
	localparam logic [2:0] ST_QSCAN = 3'd2; // walk queue: free slot or oldest match
	localparam logic [2:0] ST_TICK  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4; // commit updates, post result

	logic [2:0] state_q;

	// Configuration registers.
	logic [47:0] own_mac_q;
	logic [31:0] own_ip_q;
	logic [15:0] pend_to_q, lifetime_q;

	// Latched item.
	logic [1:0]  cmd_q;
	logic [31:0] ip_q;      // next hop for a send, sender IP for ARP
	logic [47:0] smac_q;
	logic [15:0] handle_q;
	logic        reply_q;
	logic        tgt_ok_q;
	logic [15:0] elapsed_q;

	// Tables. Valid and pending bits are flops; payloads are stored entries.
	logic [CACHE_ENTRIES-1:0] cvalid_q, cpend_q;
	logic [31:0] cip_q  [CACHE_ENTRIES];
	logic [47:0] cmac_q [CACHE_ENTRIES];
	logic [15:0] cage_q [CACHE_ENTRIES];
	logic [QUEUE_ENTRIES-1:0] qvalid_q;
	logic [31:0] qip_q  [QUEUE_ENTRIES];
	logic [15:0] qhdl_q [QUEUE_ENTRIES];
	logic [15:0] qord_q [QUEUE_ENTRIES];
	logic [15:0] order_q;

	// Scan state.
	logic [CW:0] ci_q;
	logic [QW:0] qi_q;
	logic        hit_q;
	logic [CW-1:0] hit_idx_q;
	logic        free_q;
	logic [CW-1:0] free_idx_q;
	logic [CW-1:0] old_idx_q;
	logic [15:0] old_age_q;
	logic        qfound_q;
	logic [QW-1:0] qidx_q;
	logic [15:0] qbest_q;

	// Output register.
	logic    ovalid_q;
	result_t res_q;

	logic in_fire, out_fire;
	assign in_fire  = in_valid && !in_stall;
	assign out_fire = ovalid_q && !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);

	assign out_valid  = ovalid_q;
	assign action     = res_q.action;
	assign dest_mac   = res_q.dest_mac;
	assign arp_target = res_q.arp_target;
	assign out_handle = res_q.out_handle;

	// Frames that pass the address filter and parsed cleanly.
	logic frame_for_us, item_noop;
	assign frame_for_us = (frame_dst_mac == BCAST_MAC || frame_dst_mac == own_mac_q) &&
		payload_ok;
	assign item_noop = !(cmd == CMD_SEND || cmd == CMD_TICK ||
		(cmd == CMD_FRAME && frame_for_us &&
		(frame_kind == KIND_ARP || frame_kind == KIND_IPV4)));

	// Shared compare unit, one cache entry per cycle.
	logic [CW-1:0] cidx;
	logic [QW-1:0] qidx;
	logic          c_match;
	logic [16:0]   age_sum;
	logic [15:0]   age_sat;
	logic [15:0]   q_age;
	logic          q_match;
	assign cidx    = ci_q[CW-1:0];
	assign qidx    = qi_q[QW-1:0];
	assign c_match = cvalid_q[cidx] && (cip_q[cidx] == ip_q);
	assign age_sum = {1'b0, cage_q[cidx]} + {1'b0, elapsed_q};
	assign age_sat = age_sum[16] ? 16'hFFFF : age_sum[15:0];
	assign q_age   = order_q - qord_q[qidx];
	assign q_match = qvalid_q[qidx] && (qip_q[qidx] == ip_q);

	// Slot that a new cache entry goes to, and the slot an ARP sender is learned into.
	logic [CW-1:0] alloc_idx, learn_idx;
	assign alloc_idx = free_q ? free_idx_q : old_idx_q;
	assign learn_idx = hit_q ? hit_idx_q : alloc_idx;

	logic [CW:0] c_last;
	logic [QW:0] q_last;
	assign c_last = (CW+1)'(CACHE_ENTRIES - 1);
	assign q_last = (QW+1)'(QUEUE_ENTRIES - 1);

	// The item finishes once the output register is free or being emptied.
	logic    done_go, done_post;
	result_t done_res;
	assign done_go = (state_q == ST_DONE) && (!ovalid_q || out_fire);

	always_comb begin
		done_post = 1'b0;
		done_res  = '0;
		unique case (cmd_q)
			CMD_SEND: begin
				priority if (hit_q) begin
					if (!cpend_q[hit_idx_q]) begin
						done_post = 1'b1;
						done_res  = '{ACT_IPV4, cmac_q[hit_idx_q], 32'd0, handle_q};
					end
				end else if (!qfound_q) begin
					done_post = 1'b1;
					done_res  = '{ACT_DROP, 48'd0, 32'd0, handle_q};
				end else begin
					done_post = 1'b1;
					done_res  = '{ACT_ARP_REQ, BCAST_MAC, ip_q, handle_q};
				end
			end
			CMD_FRAME: begin
				priority if (ci_q == '0) begin
					// IPv4 delivery; no scan was done.
					done_post = 1'b1;
					done_res  = '{ACT_DELIVER, 48'd0, 32'd0, handle_q};
				end else if (!reply_q) begin
					if (tgt_ok_q) begin
						done_post = 1'b1;
						done_res  = '{ACT_ARP_REP, smac_q, ip_q, 16'd0};
					end
				end else if (qfound_q) begin
					done_post = 1'b1;
					done_res  = '{ACT_IPV4, smac_q, 32'd0, qhdl_q[qidx_q]};
				end else begin
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			own_mac_q  <= '0;
			own_ip_q   <= '0;
			pend_to_q  <= PEND_TO_RST;
			lifetime_q <= LIFETIME_RST;
			cvalid_q   <= '0;
			cpend_q    <= '0;
			qvalid_q   <= '0;
			order_q    <= '0;
			ovalid_q   <= 1'b0;
			cmd_q      <= CMD_TICK;
		end else begin
			if (done_go && done_post) begin
				ovalid_q <= 1'b1;
				res_q    <= done_res;
			end else if (out_fire) begin
				ovalid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_OWN_MAC:  own_mac_q  <= cfg_data[47:0];
					REG_OWN_IP:   own_ip_q   <= cfg_data[31:0];
					REG_PEND_TO:  pend_to_q  <= cfg_data[15:0];
					REG_LIFETIME: lifetime_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						// Items with nothing to do finish as an empty tick.
						cmd_q     <= item_noop ? CMD_TICK : cmd;
						handle_q  <= datagram_handle;
						reply_q   <= arp_is_reply;
						tgt_ok_q  <= (arp_target_ip == own_ip_q);
						smac_q    <= arp_sender_mac;
						elapsed_q <= elapsed_ms;
						ip_q      <= (cmd == CMD_SEND) ? hop_ip : arp_sender_ip;
						ci_q      <= '0;
						qi_q      <= '0;
						hit_q     <= 1'b0;
						free_q    <= 1'b0;
						qfound_q  <= 1'b0;
						old_idx_q <= '0;
						old_age_q <= '0;
						priority if (cmd == CMD_SEND) begin
							state_q <= ST_CSCAN;
						end else if (cmd == CMD_TICK) begin
							state_q <= ST_TICK;
						end else if (cmd == CMD_FRAME && frame_for_us &&
							frame_kind == KIND_ARP) begin
							state_q <= ST_CSCAN;
						end else begin
							// IPv4 delivery, or nothing to do.
							state_q <= ST_DONE;
						end
					end
				end
				ST_CSCAN: begin
					if (c_match && !hit_q) begin
						hit_q     <= 1'b1;
						hit_idx_q <= cidx;
					end
					if (!cvalid_q[cidx] && !free_q) begin
						free_q     <= 1'b1;
						free_idx_q <= cidx;
					end
					if (cvalid_q[cidx] && (ci_q == '0 || cage_q[cidx] > old_age_q)) begin
						old_idx_q <= cidx;
						old_age_q <= cage_q[cidx];
					end
					if (ci_q == c_last) begin
						state_q <= ST_QSCAN;
					end
					ci_q <= ci_q + 1'b1;
				end
				ST_QSCAN: begin
					if (cmd_q == CMD_SEND) begin
						if (!qvalid_q[qidx] && !qfound_q) begin
							qfound_q <= 1'b1;
							qidx_q   <= qidx;
						end
					end else if (q_match && (!qfound_q || q_age > qbest_q)) begin
						qfound_q <= 1'b1;
						qidx_q   <= qidx;
						qbest_q  <= q_age;
					end
					if (qi_q == q_last) begin
						state_q <= ST_DONE;
					end
					qi_q <= qi_q + 1'b1;
				end
				ST_TICK: begin
					if (cvalid_q[cidx]) begin
						cage_q[cidx] <= age_sat;
						if (age_sat >= (cpend_q[cidx] ? pend_to_q : lifetime_q)) begin
							cvalid_q[cidx] <= 1'b0;
						end
					end
					if (ci_q == c_last) begin
						cmd_q   <= CMD_TICK;
						elapsed_q <= '0;
						state_q <= ST_DONE;
					end
					ci_q <= ci_q + 1'b1;
				end
				ST_DONE: begin
					// Wait here until the previous result has left.
					if (done_go) begin
						state_q <= ST_IDLE;
						unique case (cmd_q)
							CMD_SEND: begin
								if (!hit_q && qfound_q) begin
									qvalid_q[qidx_q] <= 1'b1;
									qip_q[qidx_q]    <= ip_q;
									qhdl_q[qidx_q]   <= handle_q;
									qord_q[qidx_q]   <= order_q;
									order_q          <= order_q + 16'd1;
									cvalid_q[alloc_idx] <= 1'b1;
									cpend_q[alloc_idx]  <= 1'b1;
									cip_q[alloc_idx]    <= ip_q;
									cmac_q[alloc_idx]   <= '0;
									cage_q[alloc_idx]   <= '0;
								end
							end
							CMD_FRAME: begin
								if (ci_q != '0) begin
									cvalid_q[learn_idx] <= 1'b1;
									cpend_q[learn_idx]  <= 1'b0;
									cip_q[learn_idx]    <= ip_q;
									cmac_q[learn_idx]   <= smac_q;
									cage_q[learn_idx]   <= '0;
									if (reply_q && qfound_q) begin
										qvalid_q[qidx_q] <= 1'b0;
									end
								end
							end
							default: ;
						endcase
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[design/arc_checker.sv]
// Port-level checker for the ARP resolution cache, bound to the top level.
module arc_checker
	import arc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  action,
	input logic [47:0] dest_mac,
	input logic        cfg_ready
);
	// A transfer in blocks the input side on the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("input not blocked after transfer");

	// Config and input readiness agree.
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready == !in_stall) else $error("config ready mismatch");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(action))
		else $error("result changed under stall");

	// Requests go to broadcast.
	a_bcast: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == ACT_ARP_REQ |-> dest_mac == BCAST_MAC)
		else $error("ARP request not broadcast");

	// Actions carry only defined codes.
	a_act: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> action <= ACT_DROP) else $error("bad action code");
endmodule

bind arp_resolution_cache_top arc_checker u_arc_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .action(action),
	.dest_mac(dest_mac), .cfg_ready(cfg_ready)
);
